/* rtl/window_pixel_average_defines.svh */
// Assertion macros shared by the checker of the window pixel average block.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef WINDOW_PIXEL_AVERAGE_DEFINES_SVH
`define WINDOW_PIXEL_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define WPA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define WPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/wpa_pkg.sv */
// Shared types and constants of the window pixel average block.
// Depends on nothing; imported by the top level, its checker and the bench.
package wpa_pkg;

  // Default sizes of the image store.
  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;
  localparam int DEF_CHANNEL_BITS = 8;

  // Fixed channel count of one stored pixel.
  localparam int NUM_CHANNELS = 4;

  // Commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 9;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 2'd2;

  // Register values after reset, and the channel count limit.
  localparam logic [8:0] RST_IMAGE_WIDTH   = 9'd256;
  localparam logic [8:0] RST_IMAGE_HEIGHT  = 9'd256;
  localparam logic [2:0] RST_CHANNEL_COUNT = 3'd3;
  localparam logic [2:0] MAX_CHANNEL_COUNT = 3'd4;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_LOAD,
    ST_DIV,
    ST_FINISH
  } wpa_state_t;

endpackage

/* rtl/window_pixel_average.sv */
// Top level of the window pixel average block: image store, window scan and divider.
// Depends on wpa_pkg and wpa_ram.
//
//   channel   signals                                      transaction when
//   command   start, busy, cmd, x_pos, y_pos, radius,      start high and busy low
//             chan0_in .. chan3_in
//   result    done, avg_chan0 .. avg_chan3                 done high, one cycle
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data    cfg_valid and cfg_ready high
//
// A pixel write leaves busy low.
// A query scans the clamped window with one store read per pixel, drains the last read,
// loads the bit-serial divider and runs it over its SW-bit dividend (25 bits at the default
// sizes) before it registers the result; an empty window skips the scan and the drain
// state. The result shows in the first cycle with busy low. Reset is synchronous; it restores
// the control and configuration registers but leaves the datapath and the store undefined.
// The result side cannot stall; cfg_ready is always high.
module window_pixel_average #(
  parameter int MAX_WIDTH    = wpa_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = wpa_pkg::DEF_MAX_HEIGHT,
  parameter int CHANNEL_BITS = wpa_pkg::DEF_CHANNEL_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cmd,
  input  logic [7:0]                         x_pos,
  input  logic [7:0]                         y_pos,
  input  logic [7:0]                         radius,
  input  logic [7:0]                         chan0_in,
  input  logic [7:0]                         chan1_in,
  input  logic [7:0]                         chan2_in,
  input  logic [7:0]                         chan3_in,
  output logic                               done,
  output logic [7:0]                         avg_chan0,
  output logic [7:0]                         avg_chan1,
  output logic [7:0]                         avg_chan2,
  output logic [7:0]                         avg_chan3,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [wpa_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [wpa_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  import wpa_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = NUM_CHANNELS * CHANNEL_BITS;
  localparam int CW_W  = $clog2(MAX_WIDTH + 1);
  localparam int CW_H  = $clog2(MAX_HEIGHT + 1);
  localparam int CW_M  = (CW_W > CW_H) ? CW_W : CW_H;
  localparam int CW    = (CW_M > 10) ? CW_M : 10;
  localparam int NW    = $clog2(DEPTH + 1);
  localparam int SW    = NW + CHANNEL_BITS;
  localparam int RW    = (SW > 8) ? SW : 8;
  localparam int SCW   = $clog2(SW + 1);

  // Configuration registers.
  logic [8:0] image_width;
  logic [8:0] image_height;
  logic [2:0] channel_count;

  // Sequencer.
  wpa_state_t state, state_next;

  // Window bounds and scan position.
  logic [CW-1:0] c_first, c_last, r_last, col, row;
  logic          rd_valid;

  // Accumulators and divider lanes.
  logic [NW-1:0]  count;
  logic [SW-1:0]  sum      [NUM_CHANNELS];
  logic [SW-1:0]  quo      [NUM_CHANNELS];
  logic [NW-1:0]  rem      [NUM_CHANNELS];
  logic [SW-1:0]  quo_next [NUM_CHANNELS];
  logic [NW-1:0]  rem_next [NUM_CHANNELS];
  logic [RW-1:0]  rounded  [NUM_CHANNELS];
  logic           lane_on  [NUM_CHANNELS];
  logic [SCW-1:0] step;
  logic [7:0]     avg      [NUM_CHANNELS];

  // Combinational window arithmetic.
  logic [CW-1:0] x_ext, y_ext, rad_ext, w_lim, h_lim, x_hi, y_hi, c0, c1, r0, r1;
  logic          win_empty, in_store, query_acc, write_acc;
  logic [2:0]    nch;

  // Store ports.
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [PW-1:0] wr_data, rd_data;

  // Clamp the window to the image and to the store.
  always_comb begin
    x_ext   = CW'(x_pos);
    y_ext   = CW'(y_pos);
    rad_ext = CW'(radius);
    w_lim   = (CW'(image_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(image_width);
    h_lim   = (CW'(image_height) > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT) : CW'(image_height);
    x_hi    = x_ext + rad_ext;
    y_hi    = y_ext + rad_ext;
    c1      = (x_hi > w_lim) ? w_lim : x_hi;
    r1      = (y_hi > h_lim) ? h_lim : y_hi;
    c0      = (x_ext >= rad_ext) ? (x_ext - rad_ext) : '0;
    r0      = (y_ext >= rad_ext) ? (y_ext - rad_ext) : '0;
    win_empty = (c0 >= c1) || (r0 >= r1);
    in_store  = (x_ext < CW'(MAX_WIDTH)) && (y_ext < CW'(MAX_HEIGHT));
    nch       = (channel_count > MAX_CHANNEL_COUNT) ? MAX_CHANNEL_COUNT : channel_count;
  end

  assign query_acc = start && !busy && (cmd == CMD_QUERY);
  assign write_acc = start && !busy && (cmd == CMD_WRITE) && in_store;

  // Row-major store addresses.
  assign wr_addr = AW'(AW'(y_ext) * AW'(MAX_WIDTH) + AW'(x_ext));
  assign rd_addr = AW'(AW'(row) * AW'(MAX_WIDTH) + AW'(col));
  assign wr_data = {CHANNEL_BITS'(chan3_in), CHANNEL_BITS'(chan2_in),
                    CHANNEL_BITS'(chan1_in), CHANNEL_BITS'(chan0_in)};

  wpa_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH),
    .ADDR_BITS (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (query_acc) begin
          state_next = win_empty ? ST_LOAD : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((col == c_last) && (row == r_last)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_DIV;
      ST_DIV: begin
        if (step == SCW'(SW - 1)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State-decoded outputs.
  always_comb begin
    busy  = (state != ST_IDLE);
    rd_en = (state == ST_SCAN);
    wr_en = write_acc;
  end

  assign cfg_ready = 1'b1;

  // One restoring division step per lane, plus the final rounding.
  always_comb begin
    logic [NW:0] trial;
    logic        ge;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      trial       = {rem[k], quo[k][SW-1]};
      ge          = (trial >= {1'b0, count});
      rem_next[k] = ge ? NW'(trial - {1'b0, count}) : NW'(trial);
      quo_next[k] = {quo[k][SW-2:0], ge};
      rounded[k]  = RW'(quo[k]) + RW'({rem[k], 1'b0} > {1'b0, count});
      lane_on[k]  = (3'(k) < nch);
    end
  end

  // Control registers and configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_valid      <= 1'b0;
      done          <= 1'b0;
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      channel_count <= RST_CHANNEL_COUNT;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_SCAN);
      done     <= (state == ST_FINISH);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH:   image_width   <= cfg_data;
          CFG_IMAGE_HEIGHT:  image_height  <= cfg_data;
          CFG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath: window scan, accumulation, division and result.
  always_ff @(posedge clk) begin
    if (query_acc) begin
      c_first <= c0;
      c_last  <= c1 - 1'b1;
      r_last  <= r1 - 1'b1;
      col     <= c0;
      row     <= r0;
      count   <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        sum[k] <= '0;
      end
    end
    if (state == ST_SCAN) begin
      if (col == c_last) begin
        col <= c_first;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
    if (rd_valid) begin
      count <= count + 1'b1;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        sum[k] <= sum[k] + SW'(rd_data[k*CHANNEL_BITS +: CHANNEL_BITS]);
      end
    end
    if (state == ST_LOAD) begin
      step <= '0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        quo[k] <= sum[k];
        rem[k] <= '0;
      end
    end
    if (state == ST_DIV) begin
      step <= step + 1'b1;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        quo[k] <= quo_next[k];
        rem[k] <= rem_next[k];
      end
    end
    if (state == ST_FINISH) begin
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        avg[k] <= (lane_on[k] && (count != '0)) ? rounded[k][7:0] : 8'd0;
      end
    end
  end

  assign avg_chan0 = avg[0];
  assign avg_chan1 = avg[1];
  assign avg_chan2 = avg[2];
  assign avg_chan3 = avg[3];

endmodule

/* rtl/wpa_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the image store.
module wpa_ram #(
  parameter int WIDTH     = 32,
  parameter int DEPTH     = 65536,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [WIDTH-1:0]     wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [WIDTH-1:0]     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/wpa_checker.sv */
// Port-level checker of the window pixel average block, bound to its top level.
// Depends on wpa_pkg and window_pixel_average_defines.svh.
`include "window_pixel_average_defines.svh"

module wpa_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic cmd,
  input logic done
);

  import wpa_pkg::*;

  // A result is only shown once the block has gone idle.
  `WPA_ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy, "result strobe while busy")

  // A result always follows directly on the end of a query.
  `WPA_ASSERT_IMPLY(a_done_after_busy, clk, rst, done, $past(busy), "result without a query")

  // An accepted query occupies the block in the next cycle.
  `WPA_ASSERT_NEXT(a_query_busy, clk, rst, start && !busy && (cmd == CMD_QUERY), busy, "query not started")

  // A pixel write yields no result and leaves the block free.
  `WPA_ASSERT_NEXT(a_write_quiet, clk, rst, start && !busy && (cmd == CMD_WRITE), !busy && !done, "write caused activity")

endmodule

bind window_pixel_average wpa_checker u_wpa_checker (.*);

/* bench/window_pixel_average_test.sv */
// Self-checking bench for the window pixel average block: pixel writes and window queries.
// Depends on wpa_pkg and the window_pixel_average RTL; predicts every window mean itself.
module window_pixel_average_test;
  timeunit 1ns;
  timeprecision 1ps;

  import wpa_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int RESET_TICKS = 11;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int STORE_COLS  = DEF_MAX_WIDTH;
  localparam int STORE_ROWS  = DEF_MAX_HEIGHT;
  localparam int STORE_DEPTH = STORE_COLS * STORE_ROWS;
  localparam int WINDOW_CAP  = 400;
  localparam int IDLE_PCT    = 13;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = 2'd3;

  typedef logic [NUM_CHANNELS-1:0][7:0] chan_set_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] rad;
    chan_set_t  chans;
  } pixel_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic cmd = CMD_WRITE;
  logic [7:0] x_pos = '0;
  logic [7:0] y_pos = '0;
  logic [7:0] radius = '0;
  logic [7:0] chan0_in = '0;
  logic [7:0] chan1_in = '0;
  logic [7:0] chan2_in = '0;
  logic [7:0] chan3_in = '0;
  logic done;
  logic [7:0] avg_chan0, avg_chan1, avg_chan2, avg_chan3;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_IMAGE_WIDTH;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  // Commands waiting to be driven, and window means waiting to come back.
  pixel_cmd_t command_queue[$];
  chan_set_t  expected_means[$];
  pixel_cmd_t next_cmd;

  // Predictor state, updated on accepted transactions.
  logic [31:0] pixel_mem [0:STORE_DEPTH-1];
  logic [8:0]  live_width  = RST_IMAGE_WIDTH;
  logic [8:0]  live_height = RST_IMAGE_HEIGHT;
  logic [2:0]  live_chans  = RST_CHANNEL_COUNT;

  // Stimulus-side view: which pixels will have been written, and the planned setting.
  bit          planned_map [0:STORE_DEPTH-1];
  logic [8:0]  plan_width  = RST_IMAGE_WIDTH;
  logic [8:0]  plan_height = RST_IMAGE_HEIGHT;

  int taken_seen = 0;
  int commands_queued = 0;
  int commands_taken = 0;
  int writes_taken = 0;
  int queries_taken = 0;
  int means_checked = 0;
  int settings_used = 1;
  int fault_count = 0;
  int cycle_count = 0;

  window_pixel_average u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .x_pos     (x_pos),
    .y_pos     (y_pos),
    .radius    (radius),
    .chan0_in  (chan0_in),
    .chan1_in  (chan1_in),
    .chan2_in  (chan2_in),
    .chan3_in  (chan3_in),
    .done      (done),
    .avg_chan0 (avg_chan0),
    .avg_chan1 (avg_chan1),
    .avg_chan2 (avg_chan2),
    .avg_chan3 (avg_chan3),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Window edges after clamping to zero and to the configured image size.
  function automatic void window_bounds(input int cx, input int cy, input int rad,
                                        input logic [8:0] wreg, input logic [8:0] hreg,
                                        output int c0, output int c1,
                                        output int r0, output int r1);
    int w, h;
    w  = (wreg > STORE_COLS) ? STORE_COLS : int'(wreg);
    h  = (hreg > STORE_ROWS) ? STORE_ROWS : int'(hreg);
    c1 = (cx + rad > w) ? w : cx + rad;
    r1 = (cy + rad > h) ? h : cy + rad;
    c0 = (cx - rad < 0) ? 0 : cx - rad;
    r0 = (cy - rad < 0) ? 0 : cy - rad;
  endfunction

  // Quotient rounded up only when twice the remainder exceeds the divisor.
  function automatic logic [7:0] rounded_mean(input longint unsigned total,
                                              input longint unsigned npix);
    longint unsigned q, rem;
    if (npix == 0) return 8'd0;
    q   = total / npix;
    rem = total - q * npix;
    if (2 * rem > npix) q++;
    return 8'(q);
  endfunction

  // Expected channel means of one window query under the live setting.
  function automatic chan_set_t window_mean(input logic [7:0] cx, input logic [7:0] cy,
                                            input logic [7:0] rad);
    int c0, c1, r0, r1, nch;
    longint unsigned total [NUM_CHANNELS];
    longint unsigned npix;
    logic [31:0] pix;
    chan_set_t res;
    nch = (live_chans > MAX_CHANNEL_COUNT) ? NUM_CHANNELS : int'(live_chans);
    window_bounds(int'(cx), int'(cy), int'(rad), live_width, live_height, c0, c1, r0, r1);
    npix = 0;
    for (int k = 0; k < NUM_CHANNELS; k++) total[k] = 0;
    for (int r = r0; r < r1; r++) begin
      for (int c = c0; c < c1; c++) begin
        pix = pixel_mem[r * STORE_COLS + c];
        for (int k = 0; k < NUM_CHANNELS; k++) total[k] += pix[8*k +: 8];
        npix++;
      end
    end
    for (int k = 0; k < NUM_CHANNELS; k++)
      res[k] = (k < nch) ? rounded_mean(total[k], npix) : 8'd0;
    return res;
  endfunction

  // A query is usable when its window is empty, or small and fully written.
  function automatic bit query_reads_written(input int cx, input int cy, input int rad);
    int c0, c1, r0, r1;
    window_bounds(cx, cy, rad, plan_width, plan_height, c0, c1, r0, r1);
    if (c1 <= c0 || r1 <= r0) return 1'b1;
    if ((c1 - c0) * (r1 - r0) > WINDOW_CAP) return 1'b0;
    for (int r = r0; r < r1; r++)
      for (int c = c0; c < c1; c++)
        if (!planned_map[r * STORE_COLS + c]) return 1'b0;
    return 1'b1;
  endfunction

  // Command driver: a new transaction is offered once the last one was taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || commands_taken != taken_seen) begin
      taken_seen = commands_taken;
      if (command_queue.size() != 0 &&
          ($urandom_range(99) >= IDLE_PCT ||
           (commands_taken >= 500 && commands_taken < 720))) begin
        next_cmd = command_queue.pop_front();
        start    <= 1'b1;
        cmd      <= next_cmd.cmd;
        x_pos    <= next_cmd.x;
        y_pos    <= next_cmd.y;
        radius   <= next_cmd.rad;
        chan0_in <= next_cmd.chans[0];
        chan1_in <= next_cmd.chans[1];
        chan2_in <= next_cmd.chans[2];
        chan3_in <= next_cmd.chans[3];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: tracks accepted commands and register writes, and checks each result.
  always @(posedge clk) begin
    chan_set_t want, got;
    if (!rst) begin
      if (start && !busy) begin
        commands_taken++;
        if (cmd == CMD_WRITE) begin
          pixel_mem[{y_pos, x_pos}] = {chan3_in, chan2_in, chan1_in, chan0_in};
          writes_taken++;
        end else begin
          expected_means.push_back(window_mean(x_pos, y_pos, radius));
          queries_taken++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            live_width = cfg_data[8:0];
          end
          CFG_IMAGE_HEIGHT: begin
            live_height = cfg_data[8:0];
          end
          CFG_CHANNEL_COUNT: begin
            live_chans = cfg_data[2:0];
          end
          default: begin
          end
        endcase
      end
      if (done) begin
        got = {avg_chan3, avg_chan2, avg_chan1, avg_chan0};
        if (expected_means.size() == 0) begin
          $display("%0t: unexpected result, got %h", $time, got);
          fault_count++;
        end else begin
          want = expected_means.pop_front();
          means_checked++;
          for (int k = 0; k < NUM_CHANNELS; k++) begin
            if (got[k] !== want[k]) begin
              $display("%0t: avg_chan%0d expected %0d, got %0d", $time, k, want[k], got[k]);
              fault_count++;
            end
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d means outstanding",
               $time, cycle_count, expected_means.size());
      $display("simulation failed");
      $finish;
    end
  end

  task automatic push_write(input int px, input int py, input logic [31:0] chans);
    pixel_cmd_t item;
    item.cmd   = CMD_WRITE;
    item.x     = 8'(px);
    item.y     = 8'(py);
    item.rad   = 8'($urandom_range(255));
    item.chans = chans;
    planned_map[py * STORE_COLS + px] = 1'b1;
    command_queue.push_back(item);
    commands_queued++;
  endtask

  task automatic push_query(input int px, input int py, input int rad);
    pixel_cmd_t item;
    item.cmd   = CMD_QUERY;
    item.x     = 8'(px);
    item.y     = 8'(py);
    item.rad   = 8'(rad);
    item.chans = $urandom();
    command_queue.push_back(item);
    commands_queued++;
  endtask

  // Waits until every command has been taken and every mean has come back.
  task automatic settle();
    while (commands_taken != commands_queued || expected_means.size() != 0 || busy)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                input logic [CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Moves to a new image size and channel count once the block is idle.
  task automatic apply_setting(input logic [8:0] w, input logic [8:0] h,
                               input logic [8:0] nch);
    settle();
    write_register(CFG_IMAGE_WIDTH, w);
    write_register(CFG_IMAGE_HEIGHT, h);
    write_register(CFG_CHANNEL_COUNT, nch);
    plan_width  = w;
    plan_height = h;
    settings_used++;
  endtask

  task automatic fill_square(input int row0, input int col0, input int side);
    for (int r = row0; r < row0 + side; r++)
      for (int c = col0; c < col0 + side; c++)
        push_write(c, r, $urandom());
  endtask

  // One random command: mostly queries whose windows cover written pixels only.
  task automatic random_command(input bit corner);
    int base, px, py, rad, tries, mode;
    base = corner ? 240 : 0;
    if ($urandom_range(99) < 35) begin
      if ($urandom_range(1))
        push_write(base + $urandom_range(15), base + $urandom_range(15), $urandom());
      else
        push_write($urandom_range(255), $urandom_range(255), $urandom());
    end else begin
      tries = 0;
      do begin
        mode = $urandom_range(99);
        if (mode < 60) begin
          px  = base + $urandom_range(15);
          py  = base + $urandom_range(15);
          rad = $urandom_range(9);
        end else if (mode < 85) begin
          px  = $urandom_range(255);
          py  = $urandom_range(255);
          rad = $urandom_range(255);
        end else begin
          px  = base + $urandom_range(15);
          py  = base + $urandom_range(15);
          rad = $urandom_range(255);
        end
        tries++;
      end while (!query_reads_written(px, py, rad) && tries < 30);
      // Fall back to an empty window when no covered one turned up.
      if (!query_reads_written(px, py, rad)) rad = 0;
      push_query(px, py, rad);
    end
  endtask

  initial begin
    repeat (RESET_TICKS) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset setting: extremes, rounding ties and empty windows.
    push_write(0, 0, {8'h80, 8'h02, 8'h01, 8'hFF});
    push_write(1, 0, {8'h7F, 8'h01, 8'h00, 8'h00});
    push_write(0, 1, {8'hFE, 8'h7F, 8'h80, 8'h01});
    push_write(1, 1, {8'hCC, 8'h33, 8'h55, 8'hAA});
    push_write(255, 255, {8'h00, 8'hFF, 8'h00, 8'hFF});
    push_write(254, 255, {8'hFF, 8'h00, 8'hFF, 8'h00});
    push_write(255, 254, {8'h80, 8'h80, 8'h80, 8'h80});
    push_write(254, 254, {8'h7F, 8'h7F, 8'h7F, 8'h7F});
    push_write(128, 64, {8'hC3, 8'h3C, 8'hA5, 8'h5A});
    push_query(0, 0, 0);
    push_query(0, 0, 1);
    push_query(1, 0, 1);
    push_query(1, 1, 1);
    push_query(255, 255, 1);
    push_query(255, 255, 0);
    push_query(10, 200, 0);
    push_write(0, 0, {8'h40, 8'h30, 8'h20, 8'h10});
    push_query(1, 1, 1);

    // Full size with four channels; a written square to query over.
    apply_setting(9'd256, 9'd256, 9'd4);
    fill_square(0, 0, 16);
    repeat (100) random_command(1'b0);

    // Small image, single channel; the spare register index is also written.
    apply_setting(9'd16, 9'd16, 9'd1);
    write_register(CFG_SPARE_INDEX, 9'h1FF);
    repeat (120) random_command(1'b0);

    apply_setting(9'd8, 9'd5, 9'd3);
    repeat (100) random_command(1'b0);

    // One-pixel image: any centre and radius reads at most the corner pixel.
    apply_setting(9'd1, 9'd1, 9'd4);
    repeat (90) random_command(1'b0);

    // Zero width: every window is empty.
    apply_setting(9'd0, 9'd256, 9'd2);
    repeat (40) random_command(1'b0);

    // Oversized register values saturate to the store size and four channels.
    apply_setting(9'd300, 9'd511, 9'd7);
    fill_square(248, 248, 8);
    repeat (150) random_command(1'b1);

    // Zero height and zero channels.
    apply_setting(9'd256, 9'd0, 9'd0);
    repeat (40) random_command(1'b0);

    apply_setting(9'd12, 9'd256, 9'd5);
    repeat (100) random_command(1'b0);

    apply_setting(RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, 9'(RST_CHANNEL_COUNT));
    repeat (70) random_command(1'b0);

    settle();
    repeat (64) @(negedge clk);
    $display("Covered %0d pixel writes and %0d window queries over %0d register settings.",
             writes_taken, queries_taken, settings_used);
    $display("Compared %0d window means; %0d mismatches.", means_checked, fault_count);
    if (fault_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/wpa_pkg.sv
rtl/wpa_ram.sv
rtl/window_pixel_average.sv
rtl/wpa_checker.sv
bench/window_pixel_average_test.sv
